// ===== hdl/wsg8_pkg.sv =====
// Package for the eight-voice wavetable sound generator.
// Holds the command codes, the controller states, the controller-to-datapath bundles and
// shared constants. It depends on nothing else.
package wsg8_pkg;

    typedef enum logic [1:0] {
        CMD_REG_WRITE  = 2'd0,
        CMD_REG_READ   = 2'd1,
        CMD_WAVE_WRITE = 2'd2,
        CMD_TICK       = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_V_SEL,
        ST_V_WAVE,
        ST_V_NOISE,
        ST_V_LFSR,
        ST_T_DONE
    } state_t;

    localparam logic [1:0] CFG_STEREO = 2'd0;
    localparam logic [1:0] CFG_MUTE   = 2'd1;
    localparam logic [1:0] CFG_FRAC   = 2'd2;

    localparam logic [2:0] SLOT_LVOL  = 3'd0;
    localparam logic [2:0] SLOT_FHI   = 3'd1;
    localparam logic [2:0] SLOT_FMID  = 3'd2;
    localparam logic [2:0] SLOT_FLO   = 3'd3;
    localparam logic [2:0] SLOT_RVOL  = 3'd4;
    localparam logic [2:0] SLOT_POS   = 3'd5;

    localparam logic [17:0] LFSR_TAPS = 18'h28000;
    localparam logic [4:0]  FRAC_RESET = 5'd18;

    typedef struct packed {
        logic accept;
        logic load_read;
        logic load_tick;
        logic wave_acc;
        logic noise_acc;
        logic lfsr_step;
        logic advance;
    } dp_cmd_t;

    typedef struct packed {
        logic skip;
        logic noise;
        logic hold_zero;
        logic cnt_zero;
        logic last_voice;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== hdl/wsg8_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing else.
module wsg8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== hdl/wsg8_ctrl.sv =====
// Controller state machine of the sound generator: sequences requests and the voice walk.
// Depends on wsg8_pkg.
module wsg8_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         command,
    input  wsg8_pkg::dp_stat_t stat,
    output wsg8_pkg::dp_cmd_t  ctl
);
    wsg8_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wsg8_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            wsg8_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.accept = 1'b1;
                    if (command == wsg8_pkg::CMD_REG_READ)
                    begin
                        state_next = wsg8_pkg::ST_RD_WAIT;
                    end
                    else if (command == wsg8_pkg::CMD_TICK)
                    begin
                        state_next = wsg8_pkg::ST_V_SEL;
                    end
                end
            end
            wsg8_pkg::ST_RD_WAIT:
            begin
                if (stat.out_free)
                begin
                    ctl.load_read = 1'b1;
                    state_next = wsg8_pkg::ST_IDLE;
                end
            end
            wsg8_pkg::ST_V_SEL:
            begin
                if (stat.skip)
                begin
                    if (stat.last_voice)
                    begin
                        state_next = wsg8_pkg::ST_T_DONE;
                    end
                    else
                    begin
                        ctl.advance = 1'b1;
                    end
                end
                else if (stat.noise)
                begin
                    state_next = wsg8_pkg::ST_V_NOISE;
                end
                else
                begin
                    state_next = wsg8_pkg::ST_V_WAVE;
                end
            end
            wsg8_pkg::ST_V_WAVE:
            begin
                ctl.wave_acc = 1'b1;
                if (stat.last_voice)
                begin
                    state_next = wsg8_pkg::ST_T_DONE;
                end
                else
                begin
                    ctl.advance = 1'b1;
                    state_next = wsg8_pkg::ST_V_SEL;
                end
            end
            wsg8_pkg::ST_V_NOISE:
            begin
                ctl.noise_acc = 1'b1;
                if (!stat.hold_zero)
                begin
                    if (stat.last_voice)
                    begin
                        state_next = wsg8_pkg::ST_T_DONE;
                    end
                    else
                    begin
                        ctl.advance = 1'b1;
                        state_next = wsg8_pkg::ST_V_SEL;
                    end
                end
                else
                begin
                    state_next = wsg8_pkg::ST_V_LFSR;
                end
            end
            wsg8_pkg::ST_V_LFSR:
            begin
                if (!stat.cnt_zero)
                begin
                    ctl.lfsr_step = 1'b1;
                end
                else if (stat.last_voice)
                begin
                    state_next = wsg8_pkg::ST_T_DONE;
                end
                else
                begin
                    ctl.advance = 1'b1;
                    state_next = wsg8_pkg::ST_V_SEL;
                end
            end
            wsg8_pkg::ST_T_DONE:
            begin
                if (stat.out_free)
                begin
                    ctl.load_tick = 1'b1;
                    state_next = wsg8_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wsg8_pkg::ST_IDLE;
            end
        endcase
    end
endmodule

// ===== hdl/wsg8_dp.sv =====
// Datapath of the sound generator: voice state, register file, wave RAM, mixer and output.
// Depends on wsg8_pkg and wsg8_ram.
module wsg8_dp #(
    parameter int VOICE_COUNT = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         command,
    input  logic [7:0]         address,
    input  logic [7:0]         data,
    input  logic               stereo_mode,
    input  logic [7:0]         voice_mute_mask,
    input  logic [4:0]         frac_bits,
    input  wsg8_pkg::dp_cmd_t  ctl,
    output wsg8_pkg::dp_stat_t stat,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               result_kind,
    output logic [7:0]         read_data,
    output logic signed [15:0] left_sample,
    output logic signed [15:0] right_sample
);
    logic [19:0] freq_reg  [8];
    logic [3:0]  lvol_reg  [8];
    logic [3:0]  rvol_reg  [8];
    logic [3:0]  wf_reg    [8];
    logic [31:0] phase_reg [8];
    logic        nen_reg   [8];
    logic [15:0] hold_reg  [8];
    logic [17:0] lfsr_reg  [8];
    logic        lvl_reg   [8];

    logic [2:0]  vidx_reg;
    logic [7:0]  addr_reg;
    logic [19:0] cnt_reg;
    logic signed [11:0] lacc_reg, racc_reg;
    logic [63:0]  rf_vld_reg;
    logic [255:0] wv_vld_reg;
    logic         rf_hit_reg, wv_hit_reg;

    logic        out_valid_reg, kind_reg;
    logic [7:0]  rdata_reg;
    logic signed [15:0] left_reg, right_reg;

    logic        wr_reg_en, wr_wave_en;
    logic [2:0]  wv, wv_nxt;
    logic [7:0]  rf_rdata, wv_rdata;
    logic [5:0]  rf_raddr;
    logic [7:0]  wave_raddr;
    logic [31:0] phase_sh;
    logic [4:0]  pos;
    logic [3:0]  lv, rv_eff, nib;
    logic [4:0]  s5;
    logic signed [9:0]  lprod, rprod;
    logic signed [11:0] lout, rout;
    logic [15:0] hold_reload;
    logic [31:0] noise_sum;
    logic [7:0]  rd_value;

    assign wr_reg_en  = ctl.accept && (command == wsg8_pkg::CMD_REG_WRITE)
                        && (address[7:6] == 2'b00);
    assign wr_wave_en = ctl.accept && (command == wsg8_pkg::CMD_WAVE_WRITE);
    assign wv     = address[5:3];
    assign wv_nxt = wv + 3'd1;

    // The read address is held for as long as a read waits for the output register.
    assign rf_raddr = ctl.accept ? address[5:0] : addr_reg[5:0];

    // Current voice view, also used for the wave position read.
    assign phase_sh   = phase_reg[vidx_reg] >> frac_bits;
    assign pos        = phase_sh[4:0];
    assign wave_raddr = {wf_reg[vidx_reg], pos[4:1]};
    assign lv     = lvol_reg[vidx_reg];
    assign rv_eff = stereo_mode ? rvol_reg[vidx_reg] : 4'd0;

    // High nibble holds the even sample; an unwritten byte reads as zero.
    assign nib   = wv_hit_reg ? (pos[0] ? wv_rdata[3:0] : wv_rdata[7:4]) : 4'd0;
    assign s5    = {1'b0, nib} - 5'd8;
    assign lprod = $signed(s5) * $signed({1'b0, lv});
    assign rprod = $signed(s5) * $signed({1'b0, rv_eff});
    assign lout  = $signed({9'd0, lv[3:1]}) * 12'sd7;
    assign rout  = $signed({9'd0, rv_eff[3:1]}) * 12'sd7;

    assign hold_reload = 16'd1 << ((frac_bits >= 5'd16) ? 4'(frac_bits - 5'd16) : 4'd0);
    assign noise_sum   = phase_reg[vidx_reg] + {20'd0, freq_reg[vidx_reg][7:0], 4'd0};

    always_comb
    begin
        if (addr_reg[7:6] != 2'b00)
        begin
            rd_value = 8'd0;
        end
        else if (addr_reg[2:0] == wsg8_pkg::SLOT_POS)
        begin
            rd_value = {3'd0, pos};
        end
        else
        begin
            rd_value = rf_hit_reg ? rf_rdata : 8'd0;
        end
    end

    assign stat.skip       = ((lv == 4'd0) && (rv_eff == 4'd0)) || voice_mute_mask[vidx_reg];
    assign stat.noise      = nen_reg[vidx_reg];
    assign stat.hold_zero  = (hold_reg[vidx_reg] == 16'd0);
    assign stat.cnt_zero   = (cnt_reg == 20'd0);
    assign stat.last_voice = (vidx_reg == 3'(VOICE_COUNT - 1));
    assign stat.out_free   = !out_valid_reg || out_ready;

    wsg8_ram #(.WIDTH(8), .DEPTH(64)) u_regfile (
        .clk   (clk),
        .we    (wr_reg_en),
        .waddr (address[5:0]),
        .wdata (data),
        .raddr (rf_raddr),
        .rdata (rf_rdata)
    );

    wsg8_ram #(.WIDTH(8), .DEPTH(256)) u_waveram (
        .clk   (clk),
        .we    (wr_wave_en),
        .waddr (address),
        .wdata (data),
        .raddr (wave_raddr),
        .rdata (wv_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                freq_reg[i]  <= '0;
                lvol_reg[i]  <= '0;
                rvol_reg[i]  <= '0;
                wf_reg[i]    <= '0;
                phase_reg[i] <= '0;
                nen_reg[i]   <= 1'b0;
                hold_reg[i]  <= '0;
                lfsr_reg[i]  <= 18'd1;
                lvl_reg[i]   <= 1'b0;
            end
            vidx_reg      <= '0;
            cnt_reg       <= '0;
            rf_vld_reg    <= '0;
            wv_vld_reg    <= '0;
            rf_hit_reg    <= 1'b0;
            wv_hit_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rf_hit_reg <= rf_vld_reg[rf_raddr];
            wv_hit_reg <= wv_vld_reg[wave_raddr];
            if (wr_wave_en)
            begin
                wv_vld_reg[address] <= 1'b1;
            end
            if (wr_reg_en)
            begin
                rf_vld_reg[address[5:0]] <= 1'b1;
                case (address[2:0])
                    wsg8_pkg::SLOT_LVOL: lvol_reg[wv] <= data[3:0];
                    wsg8_pkg::SLOT_FHI:
                    begin
                        freq_reg[wv][19:16] <= data[3:0];
                        wf_reg[wv] <= data[7:4];
                    end
                    wsg8_pkg::SLOT_FMID: freq_reg[wv][15:8] <= data;
                    wsg8_pkg::SLOT_FLO:  freq_reg[wv][7:0] <= data;
                    wsg8_pkg::SLOT_RVOL:
                    begin
                        rvol_reg[wv]   <= data[3:0];
                        nen_reg[wv_nxt] <= data[7];
                    end
                    default: ;
                endcase
            end
            if (ctl.accept)
            begin
                vidx_reg <= (command == wsg8_pkg::CMD_TICK) ? 3'd0 : wv;
            end
            if (ctl.advance)
            begin
                vidx_reg <= vidx_reg + 3'd1;
            end
            if (ctl.wave_acc)
            begin
                phase_reg[vidx_reg] <= phase_reg[vidx_reg] + {12'd0, freq_reg[vidx_reg]};
            end
            if (ctl.noise_acc)
            begin
                if (hold_reg[vidx_reg] != 16'd0)
                begin
                    hold_reg[vidx_reg] <= hold_reg[vidx_reg] - 16'd1;
                end
                else
                begin
                    hold_reg[vidx_reg]  <= hold_reload;
                    phase_reg[vidx_reg] <= {20'd0, noise_sum[11:0]};
                    cnt_reg             <= noise_sum[31:12];
                end
            end
            if (ctl.lfsr_step)
            begin
                // The level flips when the two lowest bits differ.
                if (lfsr_reg[vidx_reg][1] ^ lfsr_reg[vidx_reg][0])
                begin
                    lvl_reg[vidx_reg] <= ~lvl_reg[vidx_reg];
                end
                lfsr_reg[vidx_reg] <= (lfsr_reg[vidx_reg]
                    ^ (lfsr_reg[vidx_reg][0] ? wsg8_pkg::LFSR_TAPS : 18'd0)) >> 1;
                cnt_reg <= cnt_reg - 20'd1;
            end
            if (ctl.load_read || ctl.load_tick)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            addr_reg <= address;
            lacc_reg <= '0;
            racc_reg <= '0;
        end
        if (ctl.wave_acc)
        begin
            lacc_reg <= lacc_reg + 12'(lprod);
            racc_reg <= racc_reg + 12'(rprod);
        end
        if (ctl.noise_acc)
        begin
            lacc_reg <= lvl_reg[vidx_reg] ? lacc_reg + lout : lacc_reg - lout;
            racc_reg <= lvl_reg[vidx_reg] ? racc_reg + rout : racc_reg - rout;
        end
        if (ctl.load_read)
        begin
            kind_reg  <= 1'b0;
            rdata_reg <= rd_value;
            left_reg  <= '0;
            right_reg <= '0;
        end
        if (ctl.load_tick)
        begin
            kind_reg  <= 1'b1;
            rdata_reg <= 8'd0;
            left_reg  <= {lacc_reg, 4'd0};
            right_reg <= stereo_mode ? {racc_reg, 4'd0} : {lacc_reg, 4'd0};
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = kind_reg;
    assign read_data    = rdata_reg;
    assign left_sample  = left_reg;
    assign right_sample = right_reg;
endmodule

// ===== hdl/wavetable_sound_generator_8voice_top.sv =====
// Eight-voice wavetable sound generator, top level with the configuration port.
// Writes are taken one per cycle while no read or tick is in progress; a register read
// waits in ST_RD_WAIT for the output register to be free and holds the input off meanwhile.
// A tick walks the voices one at a time: ST_V_SEL passes a skipped voice, else ST_V_WAVE or
// ST_V_NOISE follows, plus ST_V_LFSR for a reloading noise voice; ST_T_DONE loads the sample.
// Reset is asynchronous and active low; all stores read as zero afterwards and the
// configuration returns to mono, no mutes, 18 fraction bits.
module wavetable_sound_generator_8voice_top #(
    parameter int VOICE_COUNT = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         command,
    input  logic [7:0]         address,
    input  logic [7:0]         data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               result_kind,
    output logic [7:0]         read_data,
    output logic signed [15:0] left_sample,
    output logic signed [15:0] right_sample,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    logic       stereo_reg;
    logic [7:0] mute_reg;
    logic [4:0] frac_reg;
    wsg8_pkg::dp_cmd_t  ctl;
    wsg8_pkg::dp_stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stereo_reg <= 1'b0;
            mute_reg   <= 8'd0;
            frac_reg   <= wsg8_pkg::FRAC_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                wsg8_pkg::CFG_STEREO: stereo_reg <= pwdata[0];
                wsg8_pkg::CFG_MUTE:   mute_reg   <= pwdata[7:0];
                wsg8_pkg::CFG_FRAC:   frac_reg   <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            wsg8_pkg::CFG_STEREO: prdata = {31'd0, stereo_reg};
            wsg8_pkg::CFG_MUTE:   prdata = {24'd0, mute_reg};
            wsg8_pkg::CFG_FRAC:   prdata = {27'd0, frac_reg};
            default:              prdata = 32'd0;
        endcase
    end

    assign pready = 1'b1;

    wsg8_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .command  (command),
        .stat     (stat),
        .ctl      (ctl)
    );

    wsg8_dp #(.VOICE_COUNT(VOICE_COUNT)) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .command         (command),
        .address         (address),
        .data            (data),
        .stereo_mode     (stereo_reg),
        .voice_mute_mask (mute_reg),
        .frac_bits       (frac_reg),
        .ctl             (ctl),
        .stat            (stat),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .result_kind     (result_kind),
        .read_data       (read_data),
        .left_sample     (left_sample),
        .right_sample    (right_sample)
    );
endmodule

// ===== test/wavetable_sound_generator_8voice_top_tb.sv =====
// Self-checking testbench for the eight-voice wavetable sound generator.
// Depends on wsg8_pkg and wavetable_sound_generator_8voice_top; it predicts every read and
// tick result with its own model of the voices and compares them at the output handshake.
module wavetable_sound_generator_8voice_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 40_000_000;

    typedef struct {
        logic        kind;
        logic [7:0]  rdata;
        logic [15:0] left;
        logic [15:0] right;
    } audio_result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         command;
    logic [7:0]         address;
    logic [7:0]         data;
    logic               out_valid;
    logic               out_ready;
    logic               result_kind;
    logic [7:0]         read_data;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    wavetable_sound_generator_8voice_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .address(address), .data(data),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_kind(result_kind), .read_data(read_data),
        .left_sample(left_sample), .right_sample(right_sample),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Predicted state of the generator.
    logic        mdl_stereo;
    logic [7:0]  mdl_mute;
    logic [4:0]  mdl_frac;
    logic [7:0]  mdl_regs [64];
    logic [7:0]  mdl_wave [256];
    logic [19:0] mdl_freq [8];
    logic [3:0]  mdl_lvol [8];
    logic [3:0]  mdl_rvol [8];
    logic [3:0]  mdl_wform [8];
    logic [31:0] mdl_phase [8];
    logic        mdl_noise_en [8];
    logic [15:0] mdl_hold [8];
    logic [17:0] mdl_lfsr [8];
    logic        mdl_level [8];

    audio_result_t pending_results[$];
    int          error_count;
    int          in_idle_pct;
    int          out_stall_pct;
    int          stall_left;
    int          quiet_cycles;
    logic [7:0]  noise_plan;

    always #5 clk = ~clk;

    function automatic void reset_model();
        mdl_stereo = 1'b0;
        mdl_mute   = 8'd0;
        mdl_frac   = wsg8_pkg::FRAC_RESET;
        for (int i = 0; i < 64; i++) mdl_regs[i] = 8'd0;
        for (int i = 0; i < 256; i++) mdl_wave[i] = 8'd0;
        for (int v = 0; v < 8; v++)
        begin
            mdl_freq[v] = '0; mdl_lvol[v] = '0; mdl_rvol[v] = '0; mdl_wform[v] = '0;
            mdl_phase[v] = '0; mdl_noise_en[v] = 1'b0; mdl_hold[v] = '0;
            mdl_lfsr[v] = 18'd1; mdl_level[v] = 1'b0;
        end
    endfunction

    function automatic void step_noise_lfsr(int v);
        logic [17:0] s;
        s = mdl_lfsr[v];
        if (s[0] ^ s[1]) mdl_level[v] = ~mdl_level[v];
        if (s[0]) s = s ^ wsg8_pkg::LFSR_TAPS;
        mdl_lfsr[v] = s >> 1;
    endfunction

    function automatic void mix_voices(output logic [15:0] l, output logic [15:0] r);
        int lmix, rmix, lv, rv, lo, ro, smp;
        int unsigned reload, cnt;
        logic [8:0]  ra;
        logic [7:0]  wbyte;
        lmix = 0;
        rmix = 0;
        reload = 1 << ((mdl_frac >= 16) ? mdl_frac - 16 : 0);
        for (int v = 0; v < 8; v++)
        begin
            lv = int'(mdl_lvol[v]);
            rv = mdl_stereo ? int'(mdl_rvol[v]) : 0;
            if ((lv == 0 && rv == 0) || mdl_mute[v]) continue;
            if (mdl_noise_en[v])
            begin
                lo = 7 * (lv >> 1);
                ro = 7 * (rv >> 1);
                if (mdl_level[v])
                begin
                    lmix += lo; rmix += ro;
                end
                else
                begin
                    lmix -= lo; rmix -= ro;
                end
                if (mdl_hold[v] != 0)
                begin
                    mdl_hold[v]--;
                    continue;
                end
                mdl_hold[v] = 16'(reload);
                mdl_phase[v] += {20'd0, mdl_freq[v][7:0], 4'h0};
                cnt = mdl_phase[v] >> 12;
                mdl_phase[v] &= 32'hFFF;
                for (; cnt > 0; cnt--) step_noise_lfsr(v);
            end
            else
            begin
                ra = {mdl_wform[v], 5'((mdl_phase[v] >> mdl_frac) & 32'h1F)};
                wbyte = mdl_wave[ra[8:1]];
                smp = (ra[0] ? int'(wbyte[3:0]) : int'(wbyte[7:4])) - 8;
                lmix += smp * lv;
                rmix += smp * rv;
                mdl_phase[v] += {12'd0, mdl_freq[v]};
            end
        end
        l = 16'(lmix * 16);
        r = mdl_stereo ? 16'(rmix * 16) : 16'(lmix * 16);
    endfunction

    // Applies one accepted request to the model and queues the result it causes.
    function automatic void predict_request(wsg8_pkg::cmd_t cmd, logic [7:0] a, logic [7:0] d);
        audio_result_t res;
        int v;
        v = int'(a[7:3]);
        res = '{kind: 1'b0, rdata: 8'd0, left: 16'd0, right: 16'd0};
        case (cmd)
            wsg8_pkg::CMD_REG_WRITE:
            begin
                if (v < 8)
                begin
                    mdl_regs[a[5:0]] = d;
                    case (a[2:0])
                        wsg8_pkg::SLOT_LVOL: mdl_lvol[v] = d[3:0];
                        wsg8_pkg::SLOT_FHI:
                        begin
                            mdl_freq[v][19:16] = d[3:0];
                            mdl_wform[v] = d[7:4];
                        end
                        wsg8_pkg::SLOT_FMID: mdl_freq[v][15:8] = d;
                        wsg8_pkg::SLOT_FLO:  mdl_freq[v][7:0] = d;
                        wsg8_pkg::SLOT_RVOL:
                        begin
                            mdl_rvol[v] = d[3:0];
                            mdl_noise_en[(v + 1) % 8] = d[7];
                        end
                        default: ;
                    endcase
                end
            end
            wsg8_pkg::CMD_REG_READ:
            begin
                if (v < 8)
                    res.rdata = (a[2:0] == wsg8_pkg::SLOT_POS)
                                ? 8'((mdl_phase[v] >> mdl_frac) & 32'h1F)
                                : mdl_regs[a[5:0]];
                pending_results.push_back(res);
            end
            wsg8_pkg::CMD_WAVE_WRITE: mdl_wave[a] = d;
            default:
            begin
                res.kind = 1'b1;
                mix_voices(res.left, res.right);
                pending_results.push_back(res);
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        audio_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result, kind", result_kind, -1);
            else
            begin
                want = pending_results.pop_front();
                if (result_kind !== want.kind)
                    report_mismatch("result_kind", result_kind, want.kind);
                if (read_data !== want.rdata) report_mismatch("read_data", read_data, want.rdata);
                if (left_sample !== want.left)
                    report_mismatch("left_sample", left_sample, $signed(want.left));
                if (right_sample !== want.right)
                    report_mismatch("right_sample", right_sample, $signed(want.right));
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout after %0d idle cycles", quiet_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offers one request and returns at the edge where it is taken.
    task automatic send_request(wsg8_pkg::cmd_t cmd, logic [7:0] a, logic [7:0] d);
        int gap;
        @(negedge clk);
        gap = ($urandom_range(99) < in_idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        address  <= a;
        data     <= d;
        do @(posedge clk); while (!in_ready);
        predict_request(cmd, a, d);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_config(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            wsg8_pkg::CFG_STEREO: mdl_stereo = val[0];
            wsg8_pkg::CFG_MUTE:   mdl_mute = val[7:0];
            default:              mdl_frac = val[4:0];
        endcase
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0;
    endtask

    task automatic apply_config(logic st, logic [7:0] mute, logic [4:0] frac);
        wait_drained();
        write_config(wsg8_pkg::CFG_STEREO, 32'(st));
        write_config(wsg8_pkg::CFG_MUTE, 32'(mute));
        write_config(wsg8_pkg::CFG_FRAC, 32'(frac));
    endtask

    // Random request, weighted towards ticks and register traffic.
    task automatic send_random_request();
        int pick;
        logic [7:0] a, d;
        pick = $urandom_range(99);
        a = 8'($urandom_range(255));
        d = 8'($urandom_range(255));
        if (pick < 35)
            send_request(wsg8_pkg::CMD_TICK, a, d);
        else if (pick < 57)
        begin
            if ($urandom_range(9) != 0) a[7:6] = 2'b00;
            // Frequencies stay mostly below 2^16 so that noise entry costs few LFSR steps.
            if (a[2:0] == wsg8_pkg::SLOT_FHI && $urandom_range(3) != 0) d[3:0] = 4'h0;
            if (a[2:0] == wsg8_pkg::SLOT_RVOL)
            begin
                if ($urandom_range(31) == 0)
                    noise_plan[(a[5:3] + 1) % 8] = ~noise_plan[(a[5:3] + 1) % 8];
                d[7] = noise_plan[(a[5:3] + 1) % 8];
            end
            send_request(wsg8_pkg::CMD_REG_WRITE, a, d);
        end
        else if (pick < 74)
        begin
            if ($urandom_range(6) != 0) a[7:6] = 2'b00;
            send_request(wsg8_pkg::CMD_REG_READ, a, d);
        end
        else
            send_request(wsg8_pkg::CMD_WAVE_WRITE, a, d);
    endtask

    task automatic test_directed();
        send_request(wsg8_pkg::CMD_REG_READ, 8'h00, 8'h00);
        send_request(wsg8_pkg::CMD_TICK, 8'h00, 8'h00);
        send_request(wsg8_pkg::CMD_WAVE_WRITE, 8'h00, 8'hFF);
        send_request(wsg8_pkg::CMD_WAVE_WRITE, 8'hFF, 8'h0F);
        send_request(wsg8_pkg::CMD_WAVE_WRITE, 8'h01, 8'h08);
        send_request(wsg8_pkg::CMD_REG_WRITE, 8'h00, 8'hFF);
        send_request(wsg8_pkg::CMD_REG_WRITE, 8'h03, 8'hFF);
        send_request(wsg8_pkg::CMD_REG_WRITE, 8'h02, 8'h00);
        send_request(wsg8_pkg::CMD_REG_WRITE, 8'h01, 8'h00);
        send_request(wsg8_pkg::CMD_TICK, 8'h00, 8'h00);
        send_request(wsg8_pkg::CMD_TICK, 8'hFF, 8'hFF);
        send_request(wsg8_pkg::CMD_REG_READ, 8'h05, 8'h00);
        send_request(wsg8_pkg::CMD_REG_READ, 8'h03, 8'h00);
        // Writes beyond the register space are dropped and read back as zero.
        send_request(wsg8_pkg::CMD_REG_WRITE, 8'h40, 8'hA5);
        send_request(wsg8_pkg::CMD_REG_WRITE, 8'hFF, 8'h5A);
        send_request(wsg8_pkg::CMD_REG_READ, 8'h40, 8'h00);
        send_request(wsg8_pkg::CMD_REG_READ, 8'hFF, 8'h00);
        // Voice seven's right volume register turns voice zero into a noise voice.
        send_request(wsg8_pkg::CMD_REG_WRITE, 8'h3C, 8'h8F);
        noise_plan[0] = 1'b1;
        repeat (4) send_request(wsg8_pkg::CMD_TICK, 8'h00, 8'h00);
        send_request(wsg8_pkg::CMD_REG_READ, 8'h3C, 8'h00);
        send_request(wsg8_pkg::CMD_REG_WRITE, 8'h3E, 8'hFF);
        send_request(wsg8_pkg::CMD_REG_READ, 8'h3E, 8'h00);
    endtask

    task automatic test_config_sweep();
        apply_config(1'b1, 8'h00, 5'd16);
        repeat (10) send_random_request();
        apply_config(1'b1, 8'hFF, 5'd31);
        repeat (10) send_random_request();
        apply_config(1'b0, 8'hA5, 5'd20);
        repeat (10) send_random_request();
    endtask

    task automatic test_backpressure();
        apply_config(1'b1, 8'h00, 5'd17);
        @(posedge clk);
        stall_left = 400;
        repeat (40) send_request(wsg8_pkg::CMD_TICK, 8'h00, 8'h00);
        wait_drained();
        repeat (30) send_random_request();
    endtask

    task automatic test_random_phases();
        int idle_in [4] = '{0, 57, 0, 23};
        int idle_out [4] = '{0, 0, 57, 23};
        for (int ph = 0; ph < 4; ph++)
        begin
            apply_config(1'($urandom_range(1)),
                         8'($urandom_range(255) & $urandom_range(255)),
                         5'($urandom_range(16, 31)));
            in_idle_pct = idle_in[ph];
            out_stall_pct = idle_out[ph];
            repeat (260) send_random_request();
        end
        in_idle_pct = 0;
        out_stall_pct = 0;
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0; command = '0; address = '0; data = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        error_count = 0; in_idle_pct = 0; out_stall_pct = 0; stall_left = 0;
        quiet_cycles = 0; noise_plan = 8'h00;
        reset_model();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_config_sweep();
        test_backpressure();
        test_random_phases();

        wait_drained();
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// ===== files.f =====
hdl/wsg8_pkg.sv
hdl/wsg8_ram.sv
hdl/wsg8_ctrl.sv
hdl/wsg8_dp.sv
hdl/wavetable_sound_generator_8voice_top.sv
test/wavetable_sound_generator_8voice_top_tb.sv
